>>> sv/eip_pkg.sv
// shared types and constants for the ethernet / ipv4 / l4 header parser
package eip_pkg;

    localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
    localparam logic [15:0] ETH_HDR_BYTES  = 16'd14;
    localparam logic [15:0] IP_MIN_BYTES   = 16'd20;
    localparam logic [6:0]  TCP_MIN_BYTES  = 7'd20;
    localparam logic [6:0]  UDP_HDR_BYTES  = 7'd8;
    localparam logic [7:0]  PROTO_TCP      = 8'd6;
    localparam logic [7:0]  PROTO_UDP      = 8'd17;
    localparam logic [3:0]  IP_VERSION4    = 4'd4;
    localparam logic [15:0] COUNT_MAX      = 16'hFFFF;

    // byte positions within the frame
    localparam logic [15:0] POS_ETYPE_HI   = 16'd12;
    localparam logic [15:0] POS_ETYPE_LO   = 16'd13;
    localparam logic [15:0] POS_VER_IHL    = 16'd14;
    localparam logic [15:0] POS_TLEN_HI    = 16'd16;
    localparam logic [15:0] POS_TLEN_LO    = 16'd17;
    localparam logic [15:0] POS_PROTO      = 16'd23;
    localparam logic [15:0] POS_SRC_FIRST  = 16'd26;
    localparam logic [15:0] POS_SRC_LAST   = 16'd29;
    localparam logic [15:0] POS_DST_FIRST  = 16'd30;
    localparam logic [15:0] POS_DST_LAST   = 16'd33;
    localparam logic [6:0]  L4_BASE        = 7'd14;
    localparam logic [6:0]  L4_TCP_OFF_POS = 7'd12;

    typedef enum logic [3:0] {
        ST_TCP_OK      = 4'd0,
        ST_UDP_OK      = 4'd1,
        ST_SHORT_FRAME = 4'd2,
        ST_NOT_IP      = 4'd3,
        ST_SHORT_IP    = 4'd4,
        ST_NOT_V4      = 4'd5,
        ST_BAD_HLEN    = 4'd6,
        ST_SHORT_TCP   = 4'd7,
        ST_OTHER_PROTO = 4'd8
    } status_t;

    // fields latched over one frame
    typedef struct packed {
        logic [15:0] cap_bytes;
        logic [15:0] wire_length;
        logic [15:0] etype;
        logic [7:0]  version_ihl;
        logic [15:0] total_length;
        logic [7:0]  protocol_byte;
        logic [31:0] source_ip;
        logic [31:0] dest_ip;
        logic [15:0] first_port;
        logic [15:0] second_port;
        logic [7:0]  tcp_offset_byte;
    } frame_rec_t;

    // header checks done in the first back stage
    typedef struct packed {
        logic        early;
        status_t     early_status;
        logic [15:0] wire_ip_bytes;
        logic [15:0] iplen;
        logic [5:0]  hlen;
        logic [6:0]  l4_off;
        logic        is_tcp;
        logic        is_udp;
        logic [31:0] source_ip;
        logic [31:0] dest_ip;
        logic [15:0] first_port;
        logic [15:0] second_port;
    } hdr_info_t;

    // verdict, last member lands in the lowest bits
    typedef struct packed {
        logic [15:0] wire_ip_bytes;
        logic [15:0] payload_bytes;
        logic [6:0]  payload_offset;
        logic [15:0] datagram_bytes;
        logic [5:0]  ip_header_bytes;
        logic [15:0] dst_port;
        logic [15:0] src_port;
        logic [31:0] dst_addr;
        logic [31:0] src_addr;
        status_t     status;
    } verdict_t;

    localparam int VERDICT_W = $bits(verdict_t);
    localparam int OUT_DATA_W = ((VERDICT_W + 7) / 8) * 8;

    // queue handshake from the front
    typedef struct packed {
        logic       push;
        frame_rec_t rec;
    } push_req_t;

endpackage

>>> sv/eip_front.sv
// front end: takes frame bytes, latches header fields, queues one record per frame
module eip_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [7:0]          frame_byte,
    input  logic                last_byte,
    input  logic [15:0]         wire_length,
    input  logic                q_full,
    output eip_pkg::push_req_t  push_req
);
    import eip_pkg::*;

    logic [15:0] cnt_reg, cnt_next;
    logic [15:0] et_reg, et_next;
    logic [7:0]  vi_reg, vi_next;
    logic [15:0] tl_reg, tl_next;
    logic [7:0]  proto_reg, proto_next;
    logic [31:0] src_reg, src_next;
    logic [31:0] dst_reg, dst_next;
    logic [15:0] fp_reg, fp_next;
    logic [15:0] sp_reg, sp_next;
    logic [7:0]  toff_reg, toff_next;
    logic [6:0]  l4_pos;
    logic        accept;

    assign in_ready = !q_full;
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        cnt_next   = (cnt_reg == COUNT_MAX) ? cnt_reg : cnt_reg + 16'd1;
        et_next    = et_reg;
        vi_next    = vi_reg;
        tl_next    = tl_reg;
        proto_next = proto_reg;
        src_next   = src_reg;
        dst_next   = dst_reg;
        fp_next    = fp_reg;
        sp_next    = sp_reg;
        toff_next  = toff_reg;
        if (cnt_reg == POS_ETYPE_HI || cnt_reg == POS_ETYPE_LO)
        begin
            et_next = {et_reg[7:0], frame_byte};
        end
        if (cnt_reg == POS_VER_IHL)
        begin
            vi_next = frame_byte;
        end
        if (cnt_reg == POS_TLEN_HI || cnt_reg == POS_TLEN_LO)
        begin
            tl_next = {tl_reg[7:0], frame_byte};
        end
        if (cnt_reg == POS_PROTO)
        begin
            proto_next = frame_byte;
        end
        if (cnt_reg >= POS_SRC_FIRST && cnt_reg <= POS_SRC_LAST)
        begin
            src_next = {src_reg[23:0], frame_byte};
        end
        if (cnt_reg >= POS_DST_FIRST && cnt_reg <= POS_DST_LAST)
        begin
            dst_next = {dst_reg[23:0], frame_byte};
        end
        // l4 start follows the ihl, including the one arriving this cycle
        l4_pos = L4_BASE + {1'b0, vi_next[3:0], 2'b00};
        if (cnt_reg == {9'd0, l4_pos} || cnt_reg == {9'd0, l4_pos + 7'd1})
        begin
            fp_next = {fp_reg[7:0], frame_byte};
        end
        if (cnt_reg == {9'd0, l4_pos + 7'd2} || cnt_reg == {9'd0, l4_pos + 7'd3})
        begin
            sp_next = {sp_reg[7:0], frame_byte};
        end
        if (cnt_reg == {9'd0, l4_pos + L4_TCP_OFF_POS})
        begin
            toff_next = frame_byte;
        end
    end

    always_comb
    begin
        push_req.push                = accept && last_byte;
        push_req.rec.cap_bytes       = cnt_next;
        push_req.rec.wire_length     = wire_length;
        push_req.rec.etype           = et_next;
        push_req.rec.version_ihl     = vi_next;
        push_req.rec.total_length    = tl_next;
        push_req.rec.protocol_byte   = proto_next;
        push_req.rec.source_ip       = src_next;
        push_req.rec.dest_ip         = dst_next;
        push_req.rec.first_port      = fp_next;
        push_req.rec.second_port     = sp_next;
        push_req.rec.tcp_offset_byte = toff_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg   <= '0;
            et_reg    <= '0;
            vi_reg    <= '0;
            tl_reg    <= '0;
            proto_reg <= '0;
            src_reg   <= '0;
            dst_reg   <= '0;
            fp_reg    <= '0;
            sp_reg    <= '0;
            toff_reg  <= '0;
        end
        else if (accept)
        begin
            if (last_byte)
            begin
                cnt_reg   <= '0;
                et_reg    <= '0;
                vi_reg    <= '0;
                tl_reg    <= '0;
                proto_reg <= '0;
                src_reg   <= '0;
                dst_reg   <= '0;
                fp_reg    <= '0;
                sp_reg    <= '0;
                toff_reg  <= '0;
            end
            else
            begin
                cnt_reg   <= cnt_next;
                et_reg    <= et_next;
                vi_reg    <= vi_next;
                tl_reg    <= tl_next;
                proto_reg <= proto_next;
                src_reg   <= src_next;
                dst_reg   <= dst_next;
                fp_reg    <= fp_next;
                sp_reg    <= sp_next;
                toff_reg  <= toff_next;
            end
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && last_byte) |=> (cnt_reg == '0))
        else $error("byte count not cleared after frame end");

endmodule

>>> sv/eip_queue.sv
// short record queue between the front and back ends
module eip_queue #(
    parameter int DEPTH = 4
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  eip_pkg::push_req_t   push_req,
    output logic                 full,
    input  logic                 pop,
    output logic                 rec_valid,
    output eip_pkg::frame_rec_t  rec
);
    import eip_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    frame_rec_t       slot_reg [DEPTH];
    logic [PTR_W-1:0] head_reg, head_next;
    logic [PTR_W-1:0] tail_reg, tail_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push;
    logic             do_pop;

    assign full      = (count_reg == CNT_W'(DEPTH));
    assign rec_valid = (count_reg != '0);
    assign rec       = slot_reg[head_reg];
    assign do_push   = push_req.push && !full;
    assign do_pop    = pop && rec_valid;

    always_comb
    begin
        head_next  = head_reg;
        tail_next  = tail_reg;
        count_next = count_reg;
        if (do_push)
        begin
            tail_next = (tail_reg == PTR_W'(DEPTH - 1)) ? '0 : tail_reg + PTR_W'(1);
        end
        if (do_pop)
        begin
            head_next = (head_reg == PTR_W'(DEPTH - 1)) ? '0 : head_reg + PTR_W'(1);
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[tail_reg] <= push_req.rec;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("queue count above depth");

    assert property (@(posedge clk) disable iff (!rst_n)
        !(push_req.push && full))
        else $error("record pushed into full queue");

    assert property (@(posedge clk) disable iff (!rst_n)
        !(pop && !rec_valid))
        else $error("record popped from empty queue");

endmodule

>>> sv/eip_back.sv
// back end: two-stage verdict computation with output register
module eip_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 rec_valid,
    input  eip_pkg::frame_rec_t  rec,
    output logic                 pop,
    output logic                 out_valid,
    input  logic                 out_ready,
    output eip_pkg::verdict_t    verdict
);
    import eip_pkg::*;

    logic      a_valid_reg;
    hdr_info_t a_reg, a_next;
    logic      o_valid_reg;
    verdict_t  o_reg, o_next;
    logic      o_adv;
    logic      a_adv;
    logic [15:0] capip;
    logic [6:0]  thl;
    logic [6:0]  hlen_w;
    logic [15:0] pay_raw;

    assign o_adv     = !o_valid_reg || out_ready;
    assign a_adv     = !a_valid_reg || o_adv;
    assign pop       = rec_valid && a_adv;
    assign out_valid = o_valid_reg;
    assign verdict   = o_reg;

    // stage a: frame, ethertype and ip header checks
    always_comb
    begin
        a_next = '0;
        capip  = rec.cap_bytes - ETH_HDR_BYTES;
        hlen_w = {1'b0, rec.version_ihl[3:0], 2'b00};
        thl    = {1'b0, rec.tcp_offset_byte[7:4], 2'b00};
        if (thl < TCP_MIN_BYTES)
        begin
            thl = TCP_MIN_BYTES;
        end
        a_next.hlen        = hlen_w[5:0];
        a_next.iplen       = (rec.total_length < capip) ? rec.total_length : capip;
        a_next.is_tcp      = (rec.protocol_byte == PROTO_TCP);
        a_next.is_udp      = (rec.protocol_byte == PROTO_UDP);
        a_next.source_ip   = rec.source_ip;
        a_next.dest_ip     = rec.dest_ip;
        a_next.first_port  = rec.first_port;
        a_next.second_port = rec.second_port;
        if (a_next.is_tcp)
        begin
            a_next.l4_off = thl + hlen_w;
        end
        else if (a_next.is_udp)
        begin
            a_next.l4_off = UDP_HDR_BYTES + hlen_w;
        end
        else
        begin
            a_next.l4_off = hlen_w;
        end
        a_next.early_status = ST_TCP_OK;
        if (rec.cap_bytes < ETH_HDR_BYTES)
        begin
            a_next.early        = 1'b1;
            a_next.early_status = ST_SHORT_FRAME;
        end
        else if (rec.etype != ETHERTYPE_IPV4)
        begin
            a_next.early        = 1'b1;
            a_next.early_status = ST_NOT_IP;
        end
        else
        begin
            a_next.wire_ip_bytes = (rec.wire_length > ETH_HDR_BYTES) ?
                                   rec.wire_length - ETH_HDR_BYTES : '0;
            if (capip < IP_MIN_BYTES)
            begin
                a_next.early        = 1'b1;
                a_next.early_status = ST_SHORT_IP;
            end
            else if (rec.version_ihl[7:4] != IP_VERSION4)
            begin
                a_next.early        = 1'b1;
                a_next.early_status = ST_NOT_V4;
            end
        end
    end

    // stage b: length checks and payload size
    always_comb
    begin
        o_next               = '0;
        o_next.status        = a_reg.early_status;
        o_next.wire_ip_bytes = a_reg.wire_ip_bytes;
        pay_raw = (a_reg.iplen > {9'd0, a_reg.l4_off}) ?
                  a_reg.iplen - {9'd0, a_reg.l4_off} : '0;
        if (!a_reg.early)
        begin
            o_next.ip_header_bytes = a_reg.hlen;
            o_next.datagram_bytes  = a_reg.iplen;
            if (a_reg.iplen < {10'd0, a_reg.hlen})
            begin
                o_next.status = ST_BAD_HLEN;
            end
            else
            begin
                o_next.src_addr = a_reg.source_ip;
                o_next.dst_addr = a_reg.dest_ip;
                if (a_reg.is_tcp)
                begin
                    if (a_reg.iplen < {9'd0, {1'b0, a_reg.hlen} + TCP_MIN_BYTES})
                    begin
                        o_next.status = ST_SHORT_TCP;
                    end
                    else
                    begin
                        o_next.status         = ST_TCP_OK;
                        o_next.src_port       = a_reg.first_port;
                        o_next.dst_port       = a_reg.second_port;
                        o_next.payload_offset = a_reg.l4_off;
                        o_next.payload_bytes  = pay_raw;
                    end
                end
                else if (a_reg.is_udp)
                begin
                    o_next.status         = ST_UDP_OK;
                    o_next.src_port       = a_reg.first_port;
                    o_next.dst_port       = a_reg.second_port;
                    o_next.payload_offset = a_reg.l4_off;
                    o_next.payload_bytes  = pay_raw;
                end
                else
                begin
                    o_next.status         = ST_OTHER_PROTO;
                    o_next.payload_offset = a_reg.l4_off;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            o_valid_reg <= 1'b0;
        end
        else
        begin
            if (a_adv)
            begin
                a_valid_reg <= rec_valid;
            end
            if (o_adv)
            begin
                o_valid_reg <= a_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            a_reg <= a_next;
        end
        if (o_adv && a_valid_reg)
        begin
            o_reg <= o_next;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        o_valid_reg |-> (o_reg.status <= ST_OTHER_PROTO))
        else $error("verdict status out of range");

    assert property (@(posedge clk) disable iff (!rst_n)
        (o_valid_reg && (o_reg.status == ST_SHORT_FRAME || o_reg.status == ST_NOT_IP))
        |-> (o_reg.wire_ip_bytes == '0 && o_reg.src_addr == '0))
        else $error("non-ip verdict carries header fields");

endmodule

>>> sv/eth_ipv4_l4_header_parser.sv
// top level of the ethernet / ipv4 / tcp-udp header parser
// Takes one captured frame byte per clock with no gaps needed between frames;
// the input stalls only when the record queue of QUEUE_DEPTH frames is full.
// One verdict per frame is presented after the record passes through the queue,
// which it enters at the edge that takes the last byte, then the header-check
// stage and the length-check stage into the output register; the back end
// retires one verdict per clock while the output is ready.
module eth_ipv4_l4_header_parser #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [23:0]                      s_axis_tdata,  // frame_byte, wire_length
    input  logic                             s_axis_tlast,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    output logic [eip_pkg::OUT_DATA_W-1:0]   m_axis_tdata   // status, src_addr, dst_addr,
                                                            // src_port, dst_port,
                                                            // ip_header_bytes,
                                                            // datagram_bytes,
                                                            // payload_offset,
                                                            // payload_bytes, wire_ip_bytes
);
    import eip_pkg::*;

    push_req_t  push_req;
    logic       q_full;
    logic       q_pop;
    logic       q_valid;
    frame_rec_t q_rec;
    verdict_t   verdict;

    eip_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (s_axis_tvalid),
        .in_ready    (s_axis_tready),
        .frame_byte  (s_axis_tdata[7:0]),
        .last_byte   (s_axis_tlast),
        .wire_length (s_axis_tdata[23:8]),
        .q_full      (q_full),
        .push_req    (push_req)
    );

    eip_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push_req  (push_req),
        .full      (q_full),
        .pop       (q_pop),
        .rec_valid (q_valid),
        .rec       (q_rec)
    );

    eip_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .rec_valid (q_valid),
        .rec       (q_rec),
        .pop       (q_pop),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .verdict   (verdict)
    );

    assign m_axis_tdata = {{(OUT_DATA_W - VERDICT_W){1'b0}}, verdict};

endmodule
